### rtl/crmp_pkg.sv
// Shared types and constants for the convolution, clamp and pooling block.
package crmp_pkg;

    localparam int KROWS       = 3;
    localparam int KCOLS       = 3;
    localparam int KSIZE       = KROWS * KCOLS;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int DIM_W       = 12;
    localparam int COL_W       = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] KIND_COEFF = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    localparam logic [3:0] CFG_WIDTH  = 4'd0;
    localparam logic [3:0] CFG_HEIGHT = 4'd1;
    localparam logic [3:0] CFG_SCALE  = 4'd2;
    localparam logic [3:0] CFG_BIAS   = 4'd3;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef logic [7:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef struct packed {
        column_t          col_l;
        column_t          col_m;
        column_t          col_n;
        logic             do_a;
        logic             do_b;
        logic [COL_W-1:0] col;
        logic             y_odd;
    } conv_job_t;

    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        logic [7:0] value;
    } coeff_wr_t;

endpackage

### rtl/conv2d_relu_maxpool2x2.sv
// Top level: 3x3 convolution, scale/bias clamp to 0..255 and 2x2 max pooling on a pixel stream.
// The front end takes at most one pixel or drain beat per cycle, and only while the job queue
// has room, into three line buffers and builds window columns; a four-entry job queue feeds the
// back end, which takes one job at a time and for each convolution output runs MAC, Q4.12
// multiply, clamp and pool update in that order, then holds each pooled result until m_tready
// is high before it goes on. A coefficient beat is taken only once all earlier work has
// drained. Every result beat carries m_tlast high, since one beat releases at most one pooled
// pixel. No clearing pass is needed after reset.
module conv2d_relu_maxpool2x2 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // coeff_index[3:0], coeff_value[11:4], pixel[19:12], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pooled_pixel[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import crmp_pkg::*;

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic signed [15:0] scale_reg, bias_reg;

    conv_job_t          push_job, head_job;
    logic               job_push, job_pop, q_empty, back_idle;
    logic [QCNT_W-1:0]  q_count;
    coeff_wr_t          coeff_wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            scale_reg  <= 16'sd4096;
            bias_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_SCALE:  scale_reg  <= cfg_data;
                CFG_BIAS:   bias_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    crmp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .back_idle  (back_idle),
        .q_count    (q_count),
        .job        (push_job),
        .job_push   (job_push),
        .coeff_wr   (coeff_wr)
    );

    crmp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .din     (push_job),
        .pop     (job_pop),
        .dout    (head_job),
        .count   (q_count),
        .empty   (q_empty)
    );

    crmp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_in    (head_job),
        .q_empty   (q_empty),
        .pop       (job_pop),
        .coeff_wr  (coeff_wr),
        .scale_cfg (scale_reg),
        .bias_cfg  (bias_reg),
        .idle      (back_idle),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/crmp_fifo.sv
// Short job queue between the stream front end and the compute back end.
module crmp_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  crmp_pkg::conv_job_t         din,
    input  logic                        pop,
    output crmp_pkg::conv_job_t         dout,
    output logic [crmp_pkg::QCNT_W-1:0] count,
    output logic                        empty
);
    import crmp_pkg::*;

    conv_job_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign count = count_reg;
    assign empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH) || pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue underflow");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |->
        (wr_ptr_reg == rd_ptr_reg)) else $error("queue pointers disagree with count");

endmodule

### rtl/crmp_front.sv
// Stream front end: position tracking, line buffers and window columns.
module crmp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,
    input  logic [1:0]                  s_tuser,
    input  logic [crmp_pkg::DIM_W-1:0]  width_cfg,
    input  logic [crmp_pkg::DIM_W-1:0]  height_cfg,
    input  logic                        back_idle,
    input  logic [crmp_pkg::QCNT_W-1:0] q_count,
    output crmp_pkg::conv_job_t         job,
    output logic                        job_push,
    output crmp_pkg::coeff_wr_t         coeff_wr
);
    import crmp_pkg::*;

    pix_t             line_mem [KROWS][MAX_WIDTH];
    pix_t             rd_reg [KROWS];

    logic [DIM_W-1:0] col_reg, row_reg;
    logic [1:0]       rmod_reg;
    column_t          col_l_reg, col_m_reg;

    logic             b_valid_reg, b_do_a_reg, b_do_b_reg, b_top0_reg, b_y_odd_reg;
    pix_t             b_pix_reg;
    logic [1:0]       b_slot_reg;
    logic [COL_W-1:0] b_col_reg;

    logic [1:0]       kind;
    logic             is_pos, accept, room, idle_all;
    logic [DIM_W-1:0] w, h, total, r0, c_full, cn, col_next, row_next;
    logic [1:0]       m0, rmod_next;
    logic [COL_W-1:0] c;
    pix_t             pix_in, top_raw, mid_raw;
    logic             produce;
    column_t          col_n;

    assign kind   = s_tuser;
    assign is_pos = (kind == KIND_PIXEL) || (kind == KIND_DRAIN);
    assign accept = s_tvalid && s_tready;

    assign w = (width_cfg == '0) ? DIM_W'(1) :
               (width_cfg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_cfg;
    assign h = (height_cfg == '0) ? DIM_W'(1) :
               (height_cfg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_cfg;
    assign total = h + DIM_W'(KROWS / 2);

    assign room     = (q_count + QCNT_W'(b_valid_reg)) < QCNT_W'(QUEUE_DEPTH - 1);
    assign idle_all = back_idle && (q_count == '0) && !b_valid_reg;

    always_comb begin
        case (kind)
            KIND_COEFF: s_tready = idle_all;
            KIND_PIXEL: s_tready = room;
            KIND_DRAIN: s_tready = room;
            default:    s_tready = 1'b1;
        endcase
    end

    always_comb begin
        r0     = row_reg;
        m0     = rmod_reg;
        c_full = col_reg;
        if (col_reg >= w) begin
            c_full = '0;
            r0     = row_reg + 1'b1;
            m0     = (rmod_reg == 2'd2) ? 2'd0 : rmod_reg + 1'b1;
        end
        if (r0 >= total) begin
            r0 = '0;
            m0 = 2'd0;
        end
        c  = c_full[COL_W-1:0];
        cn = c_full + 1'b1;
        col_next  = cn;
        row_next  = r0;
        rmod_next = m0;
        if (cn >= w) begin
            col_next  = '0;
            row_next  = r0 + 1'b1;
            rmod_next = (m0 == 2'd2) ? 2'd0 : m0 + 1'b1;
            if (row_next >= total) begin
                row_next  = '0;
                rmod_next = 2'd0;
            end
        end
    end

    assign pix_in  = (kind == KIND_PIXEL && r0 < h) ? s_tdata[19:12] : '0;
    assign produce = (r0 >= DIM_W'(1)) && (r0 <= h);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < KROWS; k++) begin
            if (accept && is_pos && m0 == 2'(k)) begin
                line_mem[k][c] <= pix_in;
            end
            rd_reg[k] <= line_mem[k][c];
        end
    end

    always_comb begin
        case (b_slot_reg)
            2'd0:    begin top_raw = rd_reg[1]; mid_raw = rd_reg[2]; end
            2'd1:    begin top_raw = rd_reg[2]; mid_raw = rd_reg[0]; end
            default: begin top_raw = rd_reg[0]; mid_raw = rd_reg[1]; end
        endcase
    end

    assign col_n = '{top: (b_top0_reg ? '0 : top_raw), mid: mid_raw, bot: b_pix_reg};

    assign job = '{col_l: col_l_reg, col_m: col_m_reg, col_n: col_n,
                   do_a: b_do_a_reg, do_b: b_do_b_reg, col: b_col_reg, y_odd: b_y_odd_reg};
    assign job_push = b_valid_reg && (b_do_a_reg || b_do_b_reg);

    assign coeff_wr = '{en: accept && (kind == KIND_COEFF) && (s_tdata[3:0] < 4'(KSIZE)),
                        idx: s_tdata[3:0], value: s_tdata[11:4]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            rmod_reg    <= '0;
            b_valid_reg <= 1'b0;
            col_l_reg   <= '0;
            col_m_reg   <= '0;
        end else begin
            b_valid_reg <= accept && is_pos;
            if (accept && is_pos) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                rmod_reg <= rmod_next;
            end
            if (b_valid_reg) begin
                col_l_reg <= col_m_reg;
                col_m_reg <= col_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_pos) begin
            b_pix_reg   <= pix_in;
            b_slot_reg  <= m0;
            b_col_reg   <= c;
            b_top0_reg  <= (r0 == DIM_W'(1));
            b_y_odd_reg <= ~r0[0];
            b_do_a_reg  <= produce && (c != '0);
            b_do_b_reg  <= produce && ({1'b0, c} == w - 1'b1);
        end
    end

endmodule

### rtl/crmp_back.sv
// Compute back end: kernel MAC, scaling, clamp, 2x2 max pooling and result register.
module crmp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  crmp_pkg::conv_job_t job_in,
    input  logic                q_empty,
    output logic                pop,
    input  crmp_pkg::coeff_wr_t coeff_wr,
    input  logic signed [15:0]  scale_cfg,
    input  logic signed [15:0]  bias_cfg,
    output logic                idle,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import crmp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_MUL, S_CLAMP, S_POOL, S_OUT} state_t;

    state_t             state_reg;
    conv_job_t          job_reg;
    logic               op_b_reg, out_valid_reg;
    logic signed [19:0] sum_reg;
    logic signed [35:0] prod_reg;
    pix_t               val_reg, pool_rd_reg, out_data_reg;
    logic [7:0]         kern_reg [KSIZE];
    pix_t               pool_mem [MAX_WIDTH / 2];

    logic [COL_W-1:0]   cur_x;
    column_t            left, mid, right;
    pix_t               win [KSIZE];
    logic signed [19:0] sum_c;
    logic signed [35:0] adj;
    logic signed [23:0] q;
    logic signed [24:0] biased;
    pix_t               clamped, pool_new;
    logic               emit;

    assign cur_x = op_b_reg ? job_reg.col : job_reg.col - 1'b1;
    assign left  = op_b_reg ? ((job_reg.col == '0) ? '0 : job_reg.col_m)
                            : ((job_reg.col == COL_W'(1)) ? '0 : job_reg.col_l);
    assign mid   = op_b_reg ? job_reg.col_n : job_reg.col_m;
    assign right = op_b_reg ? '0 : job_reg.col_n;

    always_comb begin
        win[0] = left.top;  win[1] = mid.top;  win[2] = right.top;
        win[3] = left.mid;  win[4] = mid.mid;  win[5] = right.mid;
        win[6] = left.bot;  win[7] = mid.bot;  win[8] = right.bot;
        sum_c = '0;
        for (int i = 0; i < KSIZE; i++) begin
            sum_c = sum_c + 20'($signed({1'b0, win[i]}) * $signed(kern_reg[i]));
        end
    end

    assign adj    = prod_reg + (prod_reg[35] ? 36'sd4095 : 36'sd0);
    assign q      = adj[35:12];
    assign biased = {q[23], q} + 25'(bias_cfg);
    assign clamped = biased[24] ? '0 : (biased > 25'sd255) ? PIX_MAX : biased[7:0];

    assign pool_new = (!job_reg.y_odd && !cur_x[0]) ? val_reg :
                      (val_reg > pool_rd_reg) ? val_reg : pool_rd_reg;
    assign emit = job_reg.y_odd && cur_x[0];

    assign pop  = (state_reg == S_IDLE) && !q_empty;
    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (coeff_wr.en) begin
            kern_reg[coeff_wr.idx] <= coeff_wr.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_POOL) begin
            pool_mem[cur_x[COL_W-1:1]] <= pool_new;
        end
        pool_rd_reg <= pool_mem[cur_x[COL_W-1:1]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_b_reg      <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= job_in;
                        op_b_reg  <= !job_in.do_a;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    sum_reg   <= sum_c;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= 36'(sum_reg) * 36'(scale_cfg);
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    val_reg   <= clamped;
                    state_reg <= S_POOL;
                end
                S_POOL: begin
                    if (emit) begin
                        out_data_reg  <= pool_new;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end else if (!op_b_reg && job_reg.do_b) begin
                        op_b_reg  <= 1'b1;
                        state_reg <= S_MAC;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        if (!op_b_reg && job_reg.do_b) begin
                            op_b_reg  <= 1'b1;
                            state_reg <= S_MAC;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = 1'b1;

    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg == (state_reg == S_OUT)) else $error("result valid outside output state");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == S_MAC) else $error("job pop did not start compute");
    a_emit_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> job_reg.y_odd && cur_x[0]) else $error("result from even cell");

endmodule
